>>> rtl/rge_pkg.sv
// rge_pkg: shared types, constants and checkword helpers for the RDS group encoder.
// Depends on nothing; used by rge_block_out, rds_group_encoder and the testbench.
`default_nettype none

package rge_pkg;

  // Radio text capacity and how it is laid out in the four byte lanes
  localparam int TEXT_CHARS = 64;
  localparam int LANES      = 4;
  localparam int ROW_AW     = $clog2((TEXT_CHARS + LANES - 1) / LANES);
  localparam int ROWS       = 1 << ROW_AW;
  localparam int CELLS      = ROWS * LANES;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_CR    = 8'h0D;

  typedef enum logic [2:0] {
    ACT_NEXT_GROUP      = 3'd0,
    ACT_WRITE_CHAR      = 3'd1,
    ACT_COMMIT_TEXT     = 3'd2,
    ACT_STATION_RESTART = 3'd3,
    ACT_NAME_RESTART    = 3'd4
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PROGRAM_ID       = 3'd0,
    REG_PROGRAM_TYPE     = 3'd1,
    REG_TRAFFIC_PROGRAM  = 3'd2,
    REG_TRAFFIC_ANNOUNCE = 3'd3,
    REG_MUSIC_FLAG       = 3'd4,
    REG_SERVICE_NAME     = 3'd5
  } cfg_reg_e;

  typedef struct packed {
    logic [2:0] action;
    logic [5:0] text_index;
    logic [7:0] text_char;
    logic [6:0] text_length;
  } in_item_t;

  typedef struct packed {
    logic [25:0] block_word;
    logic [15:0] info_word;
    logic [1:0]  block_index;
    logic        last;
  } out_item_t;

  // Information words of one group, block A in element 0
  typedef logic [3:0][15:0] group_words_t;

  // Slot schedule: bit set where the slot sends group 2A
  localparam logic [7:0] SCHED_TEXT = 8'b0101_0010;

  localparam logic [3:0][15:0] AF_WORD     = {16'h9697, 16'h9495, 16'h9293, 16'h8F90};
  localparam logic [3:0][9:0]  OFFSET_WORD = {10'h1B4, 10'h168, 10'h198, 10'h0FC};
  localparam logic [15:0]      GROUP_2A    = 16'h2000;
  localparam logic [10:0]      RDS_POLY    = 11'h5B9;

  // Checkword of each single information bit, worked out at elaboration
  function automatic logic [15:0][9:0] crc_columns();
    logic [15:0][9:0] cols;
    logic [25:0]      r;
    for (int i = 0; i < 16; i++) begin
      r = 26'(1) << (i + 10);
      for (int b = 25; b >= 10; b--) begin
        if (r[b]) begin
          r = r ^ (26'(RDS_POLY) << (b - 10));
        end
      end
      cols[i] = r[9:0];
    end
    return cols;
  endfunction

  localparam logic [15:0][9:0] CRC_COL = crc_columns();

  // The code is linear: XOR the columns of the set bits
  function automatic logic [9:0] check_word(logic [15:0] info);
    logic [9:0] c;
    c = '0;
    for (int i = 0; i < 16; i++) begin
      if (info[i]) begin
        c = c ^ CRC_COL[i];
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rge_ram.sv
// rge_ram: generic simple dual-port RAM, one write port, one registered read port.
// Read-first on a same-address collision. No dependencies.
`default_nettype none

module rge_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/rge_block_out.sv
// rge_block_out: holds one built group and hands it out block by block with checkwords.
// Depends on rge_pkg.
`default_nettype none

module rge_block_out
  import rge_pkg::*;
(
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         load_i,
  input  wire group_words_t words_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output out_item_t         out_item_o
);

  localparam logic [1:0] BLOCK_D = 2'd3;

  group_words_t words_q;
  logic [1:0]   idx_q;
  logic         valid_q;
  logic [15:0]  info;

  assign free_o = !valid_q || (out_ready_i && idx_q == BLOCK_D);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load_i) begin
      valid_q <= 1'b1;
      idx_q   <= '0;
    end else if (valid_q && out_ready_i) begin
      idx_q <= idx_q + 2'd1;
      if (idx_q == BLOCK_D) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      words_q <= words_i;
    end
  end

  assign info                   = words_q[idx_q];
  assign out_valid_o            = valid_q;
  assign out_item_o.block_word  = {info, check_word(info) ^ OFFSET_WORD[idx_q]};
  assign out_item_o.info_word   = info;
  assign out_item_o.block_index = idx_q;
  assign out_item_o.last        = (idx_q == BLOCK_D);

`ifndef NO_ASSERTIONS
  a_load_only_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> free_o)
    else $error("group loaded over one still being sent");
  a_load_starts_a: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |=> (valid_q && idx_q == 2'd0))
    else $error("loaded group does not start at block A");
`endif

endmodule

`default_nettype wire

>>> rtl/rds_group_encoder.sv
// rds_group_encoder: top level of the RDS group builder (groups 0A and 2A, four blocks each).
// Depends on rge_pkg, rge_ram (radio text lanes) and rge_block_out (block sequencer).
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+-----------------------------------------
//  in       | in_valid_i / in_ready_o          | in_item_t: one action per transfer
//  out      | out_valid_o / out_ready_i        | out_item_t: one 26-bit block per transfer
//  cfg      | cfg_we_i, cfg_index_i, cfg_wdata_i | register write, no handshake
//
// Text writes, commits and restarts are taken one per cycle, back to back, unless a built group is held.
// A next-group transfer reads the text RAM at its own edge; the group is built in the
// build stage and loaded into the block output register once that register is free,
// which raises out_valid_o. Blocks leave one per cycle while out_ready_i is high, and
// the single block output register takes a new group as its last block leaves.
// Reset clears all control state; the text RAM needs no clearing pass,
// per-character valid bits make unwritten positions read as spaces.
// While a built group waits for the output register, in_ready_o stays low.
`default_nettype none

module rds_group_encoder
  import rge_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire in_item_t              in_item_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output out_item_t                  out_item_o,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  // Configuration registers
  logic [15:0]           cfg_pi_q;
  logic [4:0]            cfg_pty_q;
  logic                  cfg_tp_q;
  logic                  cfg_ta_q;
  logic                  cfg_ms_q;
  logic [3:0][15:0]      cfg_name_q;   // character pairs, pair 3 holds characters 0 and 1

  // Encoder state
  logic [2:0]            slot_q;
  logic [1:0]            name_seg_q;
  logic [3:0]            text_seg_q;
  logic                  ab_q;
  logic [6:0]            text_len_q;
  logic                  text_changed_q;
  logic [CELLS-1:0]      valid_q;

  // Build stage: item that waits on RAM data
  logic                  s1_valid_q;
  logic                  s1_write_q;
  logic                  s1_text_q;
  logic [3:0]            s1_seg_q;
  logic                  s1_ab_q;
  logic [ROW_AW-1:0]     s1_row_q;
  logic [1:0]            s1_lane_q;
  logic [7:0]            s1_char_q;
  logic [LANES-1:0]      rd_valid_q;
  logic [LANES-1:0]      fwd_mask_q;
  logic [7:0]            fwd_char_q;

  action_e               act;
  logic                  in_fire;
  logic                  is_write_in;
  logic                  is_group_in;
  logic                  slot_text;
  logic [6:0]            commit_len;
  logic [ROW_AW-1:0]     rd_row;
  logic [LANES-1:0]      rd_valid_d;
  logic [LANES-1:0]      fwd_mask_d;
  logic                  s1_wr_exec;
  logic                  grp_load;
  logic                  out_free;
  logic [LANES-1:0][7:0] ram_rdata;
  logic [LANES-1:0][7:0] lane_char;
  logic [LANES-1:0][7:0] pad_char;
  logic                  char_differs;
  logic                  changed_eff;
  group_words_t          words;

  assign act         = action_e'(in_item_i.action);
  assign in_fire     = in_valid_i && in_ready_o;
  assign is_write_in = (act == ACT_WRITE_CHAR)
                       && ({1'b0, in_item_i.text_index} < 7'(TEXT_CHARS));
  assign is_group_in = (act == ACT_NEXT_GROUP);
  assign slot_text   = SCHED_TEXT[slot_q];
  assign commit_len  = (in_item_i.text_length > 7'(TEXT_CHARS)) ? 7'(TEXT_CHARS)
                                                                : in_item_i.text_length;

  // A character write goes through the build stage (compare, then store); it never stalls
  assign s1_wr_exec = s1_valid_q && s1_write_q;
  assign grp_load   = s1_valid_q && !s1_write_q && out_free;
  assign in_ready_o = !s1_valid_q || s1_write_q || out_free;

  // RAM read row: the written character's row, or the row of the next text segment
  assign rd_row = is_write_in ? in_item_i.text_index[ROW_AW+1:2] : text_seg_q[ROW_AW-1:0];

  // The RAM reads old data when the build stage stores to the row being read: forward it
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      fwd_mask_d[l] = s1_wr_exec && (s1_row_q == rd_row) && (s1_lane_q == l[1:0]);
      rd_valid_d[l] = valid_q[{rd_row, l[1:0]}] || fwd_mask_d[l];
    end
  end

  for (genvar g = 0; g < LANES; g++) begin : g_lane
    rge_ram #(
      .WIDTH (8),
      .DEPTH (ROWS)
    ) u_text_ram (
      .clk_i   (clk_i),
      .we_i    (s1_wr_exec && (s1_lane_q == 2'(g))),
      .waddr_i (s1_row_q),
      .wdata_i (s1_char_q),
      .re_i    (in_fire),
      .raddr_i (rd_row),
      .rdata_o (ram_rdata[g])
    );
  end

  // Stored characters; never written reads as a space
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      if (fwd_mask_q[l]) begin
        lane_char[l] = fwd_char_q;
      end else if (rd_valid_q[l]) begin
        lane_char[l] = ram_rdata[l];
      end else begin
        lane_char[l] = CHAR_SPACE;
      end
    end
  end

  assign char_differs = (lane_char[s1_lane_q] != s1_char_q);
  // A commit in the same cycle must see the change found by the write ahead of it
  assign changed_eff  = text_changed_q || (s1_wr_exec && char_differs);

  // Padded text: stored text, CR at the end mark, then spaces
  always_comb begin
    logic [6:0] pos;
    for (int l = 0; l < LANES; l++) begin
      pos = {1'b0, s1_seg_q, l[1:0]};
      if (pos >= 7'(TEXT_CHARS)) begin
        pad_char[l] = CHAR_SPACE;
      end else if (pos < text_len_q) begin
        pad_char[l] = lane_char[l];
      end else if (pos == text_len_q) begin
        pad_char[l] = CHAR_CR;
      end else begin
        pad_char[l] = CHAR_SPACE;
      end
    end
  end

  // Information words of the group in the build stage
  always_comb begin
    words[0] = cfg_pi_q;
    if (s1_text_q) begin
      words[1] = GROUP_2A | {5'b0, cfg_tp_q, cfg_pty_q, s1_ab_q, s1_seg_q};
      words[2] = {pad_char[0], pad_char[1]};
      words[3] = {pad_char[2], pad_char[3]};
    end else begin
      // DI carries the stereo bit on the last address only
      words[1] = {5'b0, cfg_tp_q, cfg_pty_q, cfg_ta_q, cfg_ms_q,
                  (s1_seg_q[1:0] == 2'd3), s1_seg_q[1:0]};
      words[2] = AF_WORD[s1_seg_q[1:0]];
      words[3] = cfg_name_q[~s1_seg_q[1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_pi_q       <= '0;
      cfg_pty_q      <= '0;
      cfg_tp_q       <= 1'b0;
      cfg_ta_q       <= 1'b0;
      cfg_ms_q       <= 1'b0;
      cfg_name_q     <= {LANES * 2{CHAR_SPACE}};
      slot_q         <= '0;
      name_seg_q     <= '0;
      text_seg_q     <= '0;
      ab_q           <= 1'b0;
      text_len_q     <= '0;
      text_changed_q <= 1'b0;
      valid_q        <= '0;
      s1_valid_q     <= 1'b0;
      s1_write_q     <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_reg_e'(cfg_index_i))
          REG_PROGRAM_ID:       cfg_pi_q   <= cfg_wdata_i[15:0];
          REG_PROGRAM_TYPE:     cfg_pty_q  <= cfg_wdata_i[4:0];
          REG_TRAFFIC_PROGRAM:  cfg_tp_q   <= cfg_wdata_i[0];
          REG_TRAFFIC_ANNOUNCE: cfg_ta_q   <= cfg_wdata_i[0];
          REG_MUSIC_FLAG:       cfg_ms_q   <= cfg_wdata_i[0];
          REG_SERVICE_NAME:     cfg_name_q <= cfg_wdata_i;
          default: ;
        endcase
      end

      if (s1_wr_exec) begin
        valid_q[{s1_row_q, s1_lane_q}] <= 1'b1;
      end

      if (in_fire && act == ACT_COMMIT_TEXT) begin
        text_changed_q <= 1'b0;
      end else if (s1_wr_exec && char_differs) begin
        text_changed_q <= 1'b1;
      end

      if (in_fire) begin
        unique case (act)
          ACT_NEXT_GROUP: begin
            slot_q <= slot_q + 3'd1;
            if (slot_text) begin
              text_seg_q <= text_seg_q + 4'd1;
            end else begin
              name_seg_q <= name_seg_q + 2'd1;
            end
          end
          ACT_COMMIT_TEXT: begin
            if (changed_eff || commit_len != text_len_q) begin
              ab_q       <= !ab_q;
              text_seg_q <= '0;
              text_len_q <= commit_len;
            end
          end
          ACT_STATION_RESTART: begin
            name_seg_q <= '0;
            text_seg_q <= '0;
            slot_q     <= '0;
            ab_q       <= !ab_q;
          end
          ACT_NAME_RESTART: name_seg_q <= '0;
          ACT_WRITE_CHAR: ;
          default: ;
        endcase
        s1_valid_q <= is_write_in || is_group_in;
        s1_write_q <= is_write_in;
      end else if (s1_wr_exec || grp_load) begin
        s1_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_text_q  <= slot_text;
      s1_seg_q   <= slot_text ? text_seg_q : {2'b00, name_seg_q};
      s1_ab_q    <= ab_q;
      s1_row_q   <= in_item_i.text_index[ROW_AW+1:2];
      s1_lane_q  <= in_item_i.text_index[1:0];
      s1_char_q  <= in_item_i.text_char;
      rd_valid_q <= rd_valid_d;
      fwd_mask_q <= fwd_mask_d;
      fwd_char_q <= s1_char_q;
    end
  end

  rge_block_out u_block_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (grp_load),
    .words_i     (words),
    .free_o      (out_free),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

`ifndef NO_ASSERTIONS
  a_group_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_write_q && !out_free) |-> !in_ready_o)
    else $error("input taken while a built group is held");
  a_commit_clears_change: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && act == ACT_COMMIT_TEXT) |=> !text_changed_q)
    else $error("text change mark survived a commit");
  a_restart_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && act == ACT_STATION_RESTART) |=>
      (slot_q == 3'd0 && name_seg_q == 2'd0 && text_seg_q == 4'd0))
    else $error("station restart left a counter running");
`endif

endmodule

`default_nettype wire

>>> test/tb_rds_group_encoder.sv
// tb_rds_group_encoder: self-checking testbench for the RDS group encoder.
// Needs rge_pkg (item types, action and register codes) and rds_group_encoder.
`timescale 1ns / 100ps

module tb_rds_group_encoder;
  import rge_pkg::*;

  // Constants of the RDS group layout
  localparam logic [3:0][9:0]  BLOCK_OFFSET = {10'h1B4, 10'h168, 10'h198, 10'h0FC};
  localparam logic [3:0][15:0] AF_CODE      = {16'h9697, 16'h9495, 16'h9293, 16'h8F90};
  localparam logic [7:0]       TEXT_SLOTS   = 8'b0101_0010;  // slots 1, 4, 6 send 2A
  localparam logic [15:0]      TYPE_2A      = 16'h2000;
  localparam logic [10:0]      GEN_POLY     = 11'h5B9;       // x^10+x^8+x^7+x^5+x^4+x^3+1
  localparam logic [7:0]       ASCII_CR     = 8'h0D;
  localparam logic [7:0]       ASCII_SPACE  = 8'h20;
  localparam logic [2:0]       ACT_FIRST_UNUSED = 3'd5;
  localparam logic [2:0]       ACT_LAST_UNUSED  = 3'd7;
  localparam int               ITEMS_PER_PHASE  = 50;
  localparam int               PHASES           = 6;
  localparam int               SETTLE_CYCLES    = 8;
  localparam int               STALL_LIMIT      = 1000;

  // Group builder: own copy of registers and text state, queue of blocks still owed
  class group_builder;
    logic [15:0] program_id;
    logic [4:0]  program_type;
    logic        tp, ta, ms;
    logic [63:0] ps_name;
    logic [7:0]  text_store [TEXT_CHARS];
    logic [6:0]  text_len;
    logic        text_changed, ab_flag;
    logic [1:0]  name_seg;
    logic [3:0]  text_seg;
    logic [2:0]  slot;
    out_item_t   pending_blocks [$];
    int          errors, blocks_checked, groups_0a, groups_2a, ab_changes;

    function new();
      program_id = '0; program_type = '0; tp = 1'b0; ta = 1'b0; ms = 1'b0;
      ps_name = {8{ASCII_SPACE}};
      foreach (text_store[i]) text_store[i] = ASCII_SPACE;
      text_len = '0; text_changed = 1'b0; ab_flag = 1'b0;
      name_seg = '0; text_seg = '0; slot = '0;
      errors = 0; blocks_checked = 0; groups_0a = 0; groups_2a = 0; ab_changes = 0;
    endfunction

    function void write_reg(cfg_reg_e idx, logic [63:0] val);
      case (idx)
        REG_PROGRAM_ID:       program_id   = val[15:0];
        REG_PROGRAM_TYPE:     program_type = val[4:0];
        REG_TRAFFIC_PROGRAM:  tp           = val[0];
        REG_TRAFFIC_ANNOUNCE: ta           = val[0];
        REG_MUSIC_FLAG:       ms           = val[0];
        REG_SERVICE_NAME:     ps_name      = val;
        default: ;
      endcase
    endfunction

    // Bit-serial long division of info * x^10 by the generator
    function logic [9:0] checkword(logic [15:0] info);
      logic [25:0] r;
      r = {info, 10'b0};
      for (int b = 25; b >= 10; b--) begin
        if (r[b]) r = r ^ ({15'b0, GEN_POLY} << (b - 10));
      end
      return r[9:0];
    endfunction

    function logic [7:0] ps_char(int k);
      return ps_name[63 - 8*k -: 8];
    endfunction

    // Stored text, then CR right after it (if it fits), then spaces
    function logic [7:0] text_at(int pos);
      if (pos >= TEXT_CHARS) return ASCII_SPACE;
      if (pos < text_len) return text_store[pos];
      if (pos == text_len) return ASCII_CR;
      return ASCII_SPACE;
    endfunction

    function void build_group();
      logic [3:0][15:0] words;
      out_item_t        blk;
      int               base;
      words[0] = program_id;
      if (!TEXT_SLOTS[slot]) begin
        words[1] = {5'b0, tp, program_type, ta, ms, (name_seg == 2'd3), name_seg};
        words[2] = AF_CODE[name_seg];
        words[3] = {ps_char(2*int'(name_seg)), ps_char(2*int'(name_seg) + 1)};
        name_seg = name_seg + 2'd1;
        groups_0a++;
      end else begin
        base = 4*int'(text_seg);
        words[1] = TYPE_2A | {5'b0, tp, program_type, ab_flag, text_seg};
        words[2] = {text_at(base), text_at(base + 1)};
        words[3] = {text_at(base + 2), text_at(base + 3)};
        text_seg = text_seg + 4'd1;
        groups_2a++;
      end
      slot = slot + 3'd1;
      for (int k = 0; k < 4; k++) begin
        blk.block_word  = {words[k], checkword(words[k]) ^ BLOCK_OFFSET[k]};
        blk.info_word   = words[k];
        blk.block_index = 2'(k);
        blk.last        = (k == 3);
        pending_blocks.push_back(blk);
      end
    endfunction

    function void take_action(in_item_t it);
      logic [6:0] len;
      case (it.action)
        ACT_NEXT_GROUP: build_group();
        ACT_WRITE_CHAR: begin
          if (it.text_index < TEXT_CHARS) begin
            if (text_store[it.text_index] != it.text_char) text_changed = 1'b1;
            text_store[it.text_index] = it.text_char;
          end
        end
        ACT_COMMIT_TEXT: begin
          len = (it.text_length > TEXT_CHARS) ? 7'(TEXT_CHARS) : it.text_length;
          if (text_changed || len != text_len) begin
            ab_flag  = ~ab_flag;
            text_seg = '0;
            text_len = len;
            ab_changes++;
          end
          text_changed = 1'b0;
        end
        ACT_STATION_RESTART: begin
          name_seg = '0; text_seg = '0; slot = '0;
          ab_flag  = ~ab_flag;
        end
        ACT_NAME_RESTART: name_seg = '0;
        default: ;  // unused codes change nothing
      endcase
    endfunction

    function void check_block(out_item_t got);
      out_item_t want;
      if (pending_blocks.size() == 0) begin
        errors++;
        $error("block with no group pending: %h", got);
        return;
      end
      want = pending_blocks.pop_front();
      blocks_checked++;
      if (got.block_word !== want.block_word) begin
        errors++;
        $error("block_word: expected %h, got %h", want.block_word, got.block_word);
      end
      if (got.info_word !== want.info_word) begin
        errors++;
        $error("info_word: expected %h, got %h", want.info_word, got.info_word);
      end
      if (got.block_index !== want.block_index) begin
        errors++;
        $error("block_index: expected %0d, got %0d", want.block_index, got.block_index);
      end
      if (got.last !== want.last) begin
        errors++;
        $error("last: expected %b, got %b", want.last, got.last);
      end
    endfunction
  endclass

  // Everything the block sees starts at a known value
  logic                  clk_i       = 1'b0;
  logic                  rst_n       = 1'b0;
  logic                  in_valid    = 1'b0;
  logic                  in_ready_o;
  in_item_t              in_item     = '0;
  logic                  out_valid_o;
  logic                  out_ready   = 1'b0;
  out_item_t             out_item_o;
  logic                  cfg_we      = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata   = '0;

  group_builder groups = new();

  bit calm = 1'b0;          // no idling on either side while set
  int items_sent   = 0;
  int settings     = 0;
  int stall_cycles = 0;
  int ready_hold   = 0;
  int ready_pick;

  always #1 clk_i = ~clk_i;

  rds_group_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  // Monitor: values read at the edge are the pre-edge ones the block samples.
  // Output is checked before the input is noted - a block leaving at this edge
  // can never belong to an action taken at the same edge.
  always @(posedge clk_i) begin
    if (rst_n && out_valid_o && out_ready) groups.check_block(out_item_o);
    if (rst_n && in_valid && in_ready_o) groups.take_action(in_item);
    if (!rst_n || (out_valid_o && out_ready) || (in_valid && in_ready_o) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  // Receiver: runs of ready, short stalls, now and then a long one
  always @(posedge clk_i) begin
    if (calm) begin
      out_ready  <= 1'b1;
      ready_hold = 0;
    end else if (ready_hold > 0) begin
      ready_hold--;
    end else begin
      ready_pick = $urandom_range(0, 99);
      if (ready_pick < 55) begin
        out_ready  <= 1'b1;
        ready_hold = $urandom_range(0, 12);
      end else if (ready_pick < 92) begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(0, 2);
      end else begin
        out_ready  <= 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
  end

  // Watchdog: too long without any transfer or register write
  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk_i);
    $display("tb_rds_group_encoder NOT OK");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic in_item_t make_item(logic [2:0] act, logic [5:0] idx,
                                         logic [7:0] ch, logic [6:0] len);
    in_item_t it;
    it.action      = act;
    it.text_index  = idx;
    it.text_char   = ch;
    it.text_length = len;
    return it;
  endfunction

  // One input transfer, then a random gap. Entered and left on a rising edge;
  // valid is only lowered when a gap follows, so it never drops and rises in one step.
  task automatic issue(input in_item_t it);
    int gap;
    in_item  <= it;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Hold the sender until every owed block has been taken
  task automatic drain_blocks();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (groups.pending_blocks.size() != 0);
  endtask

  // Idle point: drained, and the last text write or commit surely absorbed
  task automatic quiesce();
    drain_blocks();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input cfg_reg_e idx, input logic [63:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk_i);
    groups.write_reg(idx, val);
  endtask

  task automatic load_settings(input logic [15:0] pi, input logic [4:0] pty,
                               input logic tp, input logic ta, input logic ms,
                               input logic [63:0] ps);
    write_cfg(REG_PROGRAM_ID, 64'(pi));
    write_cfg(REG_PROGRAM_TYPE, 64'(pty));
    write_cfg(REG_TRAFFIC_PROGRAM, 64'(tp));
    write_cfg(REG_TRAFFIC_ANNOUNCE, 64'(ta));
    write_cfg(REG_MUSIC_FLAG, 64'(ms));
    write_cfg(REG_SERVICE_NAME, ps);
    cfg_we <= 1'b0;
    settings++;
  endtask

  function automatic logic [7:0] pick_char(logic [5:0] idx);
    // a quarter rewrite what is stored, so commits without a change occur
    if ($urandom_range(0, 3) == 0) return groups.text_store[idx];
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [6:0] pick_length();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(65, 127));  // saturates
    return 7'($urandom_range(0, TEXT_CHARS));
  endfunction

  // Random stimulus: mostly group requests with noisy don't-care fields,
  // text updates as write bursts closed by a commit, the rest stray actions.
  task automatic random_step(input int next_pct);
    in_item_t   it;
    int         pick, n;
    logic [5:0] idx;
    pick = $urandom_range(0, 99);
    it.action      = ACT_NEXT_GROUP;
    it.text_index  = 6'($urandom_range(0, 63));
    it.text_char   = 8'($urandom_range(0, 255));
    it.text_length = 7'($urandom_range(0, 127));
    if (pick < next_pct) begin
      issue(it);
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        idx = 6'($urandom_range(0, 63));
        n   = $urandom_range(1, 8);
        for (int j = 0; j < n; j++) begin
          issue(make_item(ACT_WRITE_CHAR, idx + 6'(j), pick_char(idx + 6'(j)), 7'($urandom)));
        end
        issue(make_item(ACT_COMMIT_TEXT, 6'($urandom), 8'($urandom),
                        ($urandom_range(0, 1) != 0) ? 7'(int'(idx) + n) : pick_length()));
      end else if (pick < 55) begin
        it.action    = ACT_WRITE_CHAR;
        it.text_char = pick_char(it.text_index);
        issue(it);
      end else if (pick < 68) begin
        it.action      = ACT_COMMIT_TEXT;
        it.text_length = pick_length();
        issue(it);
      end else if (pick < 78) begin
        it.action = ACT_STATION_RESTART;
        issue(it);
      end else if (pick < 90) begin
        it.action = ACT_NAME_RESTART;
        issue(it);
      end else begin
        it.action = 3'($urandom_range(int'(ACT_FIRST_UNUSED), int'(ACT_LAST_UNUSED)));
        issue(it);
      end
    end
  endtask

  initial begin
    int  target;
    bit  paused;
    repeat (11) @(posedge clk_i);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed part, reset register values: empty text, full-length text,
    // commits with and without a change, length saturation, DI on the last
    // name segment, both restarts and an unused action code.
    issue(make_item(ACT_NEXT_GROUP, '0, '0, '0));
    issue(make_item(ACT_NEXT_GROUP, 6'h3F, 8'hFF, 7'h7F));  // empty text: CR then spaces
    issue(make_item(ACT_WRITE_CHAR, 6'd0, 8'h00, '0));
    issue(make_item(ACT_WRITE_CHAR, 6'd63, 8'hFF, '0));
    issue(make_item(ACT_WRITE_CHAR, 6'd1, 8'h41, '0));
    issue(make_item(ACT_COMMIT_TEXT, '0, '0, 7'd64));        // full text, no CR
    repeat (3) issue(make_item(ACT_NEXT_GROUP, '0, '0, '0));
    issue(make_item(ACT_COMMIT_TEXT, '0, '0, 7'd64));        // nothing changed
    issue(make_item(ACT_WRITE_CHAR, 6'd1, 8'h41, '0));       // same character again
    issue(make_item(ACT_COMMIT_TEXT, '0, '0, 7'd64));
    issue(make_item(ACT_COMMIT_TEXT, '0, '0, 7'd127));       // saturates to the same length
    issue(make_item(ACT_COMMIT_TEXT, '0, '0, 7'd2));
    repeat (2) issue(make_item(ACT_NEXT_GROUP, '0, '0, '0));  // name segment 3 carries DI
    issue(make_item(ACT_NAME_RESTART, '0, '0, '0));
    issue(make_item(ACT_NEXT_GROUP, '0, '0, '0));
    issue(make_item(ACT_LAST_UNUSED, 6'h3F, 8'hFF, 7'h7F));
    issue(make_item(ACT_STATION_RESTART, '0, '0, '0));
    repeat (2) issue(make_item(ACT_NEXT_GROUP, '0, '0, '0));
    issue(make_item(ACT_COMMIT_TEXT, '0, '0, 7'd0));

    // Random phases, each under fresh register values: all ones, all zeros,
    // then random. Phase 2 runs without idling and mostly requests groups,
    // so the text segment counter wraps; phase 3 holds the sender once.
    for (int phase = 0; phase < PHASES; phase++) begin
      quiesce();
      case (phase)
        0:       load_settings('1, '1, 1'b1, 1'b1, 1'b1, '1);
        1:       load_settings('0, '0, 1'b0, 1'b0, 1'b0, '0);
        default: load_settings(16'($urandom), 5'($urandom), 1'($urandom), 1'($urandom),
                               1'($urandom), {$urandom, $urandom});
      endcase
      calm   = (phase == 2);
      paused = 1'b0;
      target = items_sent + ITEMS_PER_PHASE;
      while (items_sent < target) begin
        random_step((phase == 2) ? 95 : 70);
        if (phase == 3 && !paused && items_sent > target - ITEMS_PER_PHASE / 2) begin
          drain_blocks();
          paused = 1'b1;
        end
      end
      calm = 1'b0;
    end

    quiesce();
    if (groups.pending_blocks.size() != 0) begin
      groups.errors++;
      $error("%0d blocks never arrived", groups.pending_blocks.size());
    end
    $display("run: %0d actions in, %0d blocks checked from %0d 0A and %0d 2A groups",
             items_sent, groups.blocks_checked, groups.groups_0a, groups.groups_2a);
    $display("     %0d text commits flipped A/B, %0d register settings", groups.ab_changes,
             settings);
    if (groups.errors == 0) begin
      $display("tb_rds_group_encoder OK");
    end else begin
      $display("tb_rds_group_encoder NOT OK");
    end
    $finish;
  end

endmodule

>>> rds_group_encoder.f
rtl/rge_pkg.sv
rtl/rge_ram.sv
rtl/rge_block_out.sv
rtl/rds_group_encoder.sv
test/tb_rds_group_encoder.sv
